@@ rtl/core/pcma_pkg.sv @@
package pcma_pkg;

    localparam int CHAN_W     = 8;
    localparam int PRICE_W    = 32;
    localparam int TREND_W    = 2;
    localparam int FILL_OUT_W = 3;

    // trend codes
    localparam logic [TREND_W-1:0] TREND_LEVEL = 2'd0;
    localparam logic [TREND_W-1:0] TREND_BELOW = 2'd1;
    localparam logic [TREND_W-1:0] TREND_ABOVE = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic [PRICE_W-1:0] price;
    } t_in_item;

    typedef struct packed {
        logic                  known;
        logic [PRICE_W-1:0]    last_price;
        logic [PRICE_W-1:0]    mean_price;
        logic [TREND_W-1:0]    trend;
        logic [FILL_OUT_W-1:0] fill;
    } t_out_item;

endpackage

@@ rtl/core/pcma_div.sv @@
// Unsigned restoring divider, STEPS quotient bits per cycle.
// The divisor is a small count, so the partial remainder stays narrow.
module pcma_div #(
    parameter int DVD_W = 35,
    parameter int DVS_W = 3,
    parameter int STEPS = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic [DVD_W-1:0]                            i_dividend,
    input  logic [DVS_W-1:0]                            i_divisor,
    output logic                                        o_done,
    output logic [((DVD_W + STEPS - 1) / STEPS) * STEPS - 1:0] o_quotient
);

    localparam int DIV_W = ((DVD_W + STEPS - 1) / STEPS) * STEPS;
    localparam int ITERS = DIV_W / STEPS;
    localparam int CNT_W = $clog2(ITERS + 1);

    logic [DIV_W-1:0] r_quo;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DIV_W-1:0] n_quo;
    logic [DVS_W:0]   n_rem;

    // STEPS restoring steps on the narrow remainder
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < STEPS; k++) begin
            n_rem = {n_rem[DVS_W-1:0], n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_dvs}) begin
                n_rem    = n_rem - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(ITERS);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DIV_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/core/per_channel_moving_average_trend.sv @@
// Per-channel moving average with trend flag.
// Input channel (i_valid / o_ready) carries a channel number and a price in
// hundredths. Output channel (o_valid / i_ready) carries one item per input:
// known flag, last price, truncated window mean, trend code and fill count.
// Items are processed one at a time. A known channel passes through the
// states META, SUM, TREND, DIV and OUT from accept to result; the window
// sum reads one history word per cycle from the single-port history
// memory, and the mean comes from a divider that retires four quotient
// bits per cycle. The next item can be taken in the same cycle as the
// result appears. An unknown channel goes from accept straight to OUT
// and on into the output register, and leaves the state untouched.
// The result sits in an output register, so a stalled receiver only blocks
// the next result from leaving; the next item is still taken meanwhile.
// Reset clears the per-channel fill and slot state through valid bits at
// once; there is no clearing pass. History words are only read once written.
module per_channel_moving_average_trend #(
    parameter int CHANNELS = 16,
    parameter int WINDOW   = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pcma_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output pcma_pkg::t_out_item o_item
);

    import pcma_pkg::*;

    localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int HIST_DEPTH = CHANNELS * WINDOW;
    localparam int HA_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SUM_W      = PRICE_W + FILL_W;
    localparam int DIV_STEPS  = 4;
    localparam int QUO_W      = ((SUM_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_META,
        S_SUM,
        S_TREND,
        S_DIV,
        S_OUT
    } t_state_e;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [FILL_W-1:0] fill;
    } t_meta;

    // memories
    logic [PRICE_W-1:0] hist_mem [HIST_DEPTH];
    t_meta              meta_mem [CHANNELS];
    logic [CHANNELS-1:0] r_meta_vld;

    t_state_e           r_state;
    logic               r_known;
    logic [CH_W-1:0]    r_ch;
    logic [PRICE_W-1:0] r_price;
    logic [HA_W-1:0]    r_base;
    t_meta              r_meta_q;
    logic               r_meta_q_vld;
    logic [FILL_W-1:0]  r_n;
    logic [FILL_W-1:0]  r_idx;
    logic               r_rd_v;
    logic [PRICE_W-1:0] r_hist_q;
    logic [SUM_W-1:0]   r_sum;
    logic [TREND_W-1:0] r_trend;
    logic [PRICE_W-1:0] r_mean;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               in_acc;
    logic               in_known;
    logic [CH_W-1:0]    in_ch;
    logic [SLOT_W-1:0]  cur_slot;
    logic [FILL_W-1:0]  cur_fill;
    t_meta              n_meta;
    logic               hist_we;
    logic [HA_W-1:0]    hist_wa;
    logic               hist_re;
    logic [HA_W-1:0]    hist_ra;
    logic [SUM_W-1:0]   scaled;
    logic [TREND_W-1:0] n_trend;
    logic               out_load;
    logic [FILL_W+FILL_OUT_W-1:0] fill_ext;
    logic               div_start;
    logic               div_done;
    logic [QUO_W-1:0]   quotient;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign in_known = ({1'b0, i_item.channel} < (CHAN_W + 1)'(CHANNELS));
    assign in_ch    = CH_W'(i_item.channel);

    // slot and fill of the addressed channel; an unused channel reads as zero
    always_comb begin
        cur_slot = r_meta_q_vld ? r_meta_q.slot : '0;
        cur_fill = r_meta_q_vld ? r_meta_q.fill : '0;
        if ({1'b0, cur_slot} >= (SLOT_W + 1)'(WINDOW)) begin
            cur_slot = '0;
        end
        n_meta.slot = (cur_slot == SLOT_W'(WINDOW - 1)) ? '0 : cur_slot + 1'b1;
        n_meta.fill = (cur_fill < FILL_W'(WINDOW)) ? cur_fill + 1'b1 : cur_fill;
    end

    // history port control
    assign hist_we = (r_state == S_META);
    assign hist_wa = r_base + HA_W'(cur_slot);
    assign hist_re = (r_state == S_SUM) && (r_idx < r_n);
    assign hist_ra = r_base + HA_W'(r_idx);

    // trend: latest * fill against the exact sum
    always_comb begin
        scaled  = SUM_W'(r_price) * SUM_W'(r_n);
        n_trend = TREND_LEVEL;
        if (r_n > FILL_W'(1)) begin
            if (scaled > r_sum) begin
                n_trend = TREND_ABOVE;
            end else if (scaled < r_sum) begin
                n_trend = TREND_BELOW;
            end
        end
    end

    assign div_start = (r_state == S_TREND);
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || i_ready);
    assign fill_ext  = (FILL_W + FILL_OUT_W)'(r_n);

    pcma_div #(
        .DVD_W (SUM_W),
        .DVS_W (FILL_W),
        .STEPS (DIV_STEPS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // history memory
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            hist_mem[hist_wa] <= r_price;
        end
        if (hist_re) begin
            r_hist_q <= hist_mem[hist_ra];
        end
    end

    // per-channel slot / fill memory
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            meta_mem[r_ch] <= n_meta;
        end
        if (in_acc) begin
            r_meta_q <= meta_mem[in_ch];
        end
    end

    // valid bits of the slot / fill memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_vld <= '0;
        end else if (hist_we) begin
            r_meta_vld[r_ch] <= 1'b1;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_known      <= in_known;
                        r_ch         <= in_ch;
                        r_price      <= i_item.price;
                        r_base       <= HA_W'(in_ch * WINDOW);
                        r_meta_q_vld <= r_meta_vld[in_ch];
                        r_state      <= in_known ? S_META : S_OUT;
                    end
                end
                S_META: begin
                    r_n     <= n_meta.fill;
                    r_idx   <= '0;
                    r_sum   <= '0;
                    r_rd_v  <= 1'b0;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_rd_v <= hist_re;
                    if (hist_re) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_rd_v) begin
                        r_sum <= r_sum + SUM_W'(r_hist_q);
                    end
                    if ((r_idx == r_n) && !r_rd_v) begin
                        r_state <= S_TREND;
                    end
                end
                S_TREND: begin
                    r_trend <= n_trend;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_mean  <= quotient[PRICE_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        if (r_known) begin
                            r_out.known      <= 1'b1;
                            r_out.last_price <= r_price;
                            r_out.mean_price <= r_mean;
                            r_out.trend      <= r_trend;
                            r_out.fill       <= fill_ext[FILL_OUT_W-1:0];
                        end else begin
                            r_out <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
